>>> rtl/deam_pkg.sv
`default_nettype none

package deam_pkg;

    localparam int unsigned LIMIT_W   = 17;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned TEMP_W    = 12;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned IN_DATA_W = 128;
    localparam int unsigned OUT_DATA_W = 144;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1800;

    localparam logic [KIND_W-1:0] ALERT_OPEN   = 2'd0;
    localparam logic [KIND_W-1:0] ALERT_CLOSED = 2'd1;
    localparam logic [KIND_W-1:0] ALERT_LONG   = 2'd2;
    localparam logic [KIND_W-1:0] ALERT_BAD    = 2'd3;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_OPEN  = 2'd1,
        PEND_CLOSE = 2'd2,
        PEND_LONG  = 2'd3
    } t_pend;

    typedef struct packed {
        logic                     door_is_open;
        logic [WORD_W-1:0]        now_seconds;
        logic signed [TEMP_W-1:0] probe1_temp;
        logic signed [TEMP_W-1:0] probe2_temp;
        logic [WORD_W-1:0]        latitude_word;
        logic [WORD_W-1:0]        longitude_word;
        logic                     enqueue_ok;
        logic                     sync_ok;
    } t_in;

    typedef struct packed {
        logic               door_latched_open;
        logic [WORD_W-1:0]  opened_at;
        logic               long_alert_done;
        logic [COUNT_W-1:0] opening_count;
        t_pend              pending_kind;
        logic [WORD_W-1:0]  pending_open_sec;
        logic [WORD_W-1:0]  pending_lat;
        logic [WORD_W-1:0]  pending_lon;
        logic               pending_enqueued;
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]        alert_kind;
        logic                     alert_door_flag;
        logic [WORD_W-1:0]        open_seconds;
        logic [WORD_W-1:0]        alert_latitude;
        logic [WORD_W-1:0]        alert_longitude;
        logic signed [TEMP_W-1:0] alert_temp1;
        logic signed [TEMP_W-1:0] alert_temp2;
        logic                     note_added;
        logic                     delivered;
        logic [COUNT_W-1:0]       open_event_count;
        logic                     last_of_item;
    } t_result;

    typedef struct packed {
        logic any;
        logic two;
    } t_emit;

    function automatic t_result f_attempt(
        input t_pend              pend,
        input logic               enq_done,
        input logic [WORD_W-1:0]  osec,
        input logic [WORD_W-1:0]  lat,
        input logic [WORD_W-1:0]  lon,
        input t_in                it,
        input logic [COUNT_W-1:0] cnt
    );
        t_result r;
        r = '0;
        unique case (pend) inside
            PEND_NONE,
            PEND_OPEN:  r.alert_kind = ALERT_OPEN;
            PEND_CLOSE: r.alert_kind = ALERT_CLOSED;
            PEND_LONG:  r.alert_kind = ALERT_LONG;
            default:    r.alert_kind = ALERT_OPEN;
        endcase
        r.alert_door_flag  = (pend != PEND_CLOSE);
        r.open_seconds     = osec;
        r.alert_latitude   = lat;
        r.alert_longitude  = lon;
        r.alert_temp1      = it.probe1_temp;
        r.alert_temp2      = it.probe2_temp;
        r.note_added       = !enq_done && it.enqueue_ok;
        r.delivered        = (enq_done || it.enqueue_ok) && it.sync_ok;
        r.open_event_count = cnt;
        r.last_of_item     = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/deam_step.sv
`default_nettype none

module deam_step (
    input  deam_pkg::t_state                  i_state,
    input  deam_pkg::t_in                     i_item,
    input  logic [deam_pkg::LIMIT_W-1:0]      i_limit,
    output deam_pkg::t_state                  o_state,
    output deam_pkg::t_result                 o_res0,
    output deam_pkg::t_result                 o_res1,
    output deam_pkg::t_emit                   o_emit
);

    deam_pkg::t_state  s;
    deam_pkg::t_result ra;
    deam_pkg::t_result rb;
    logic [deam_pkg::WORD_W-1:0] dur;
    logic retry_hit;
    logic event_hit;

    assign dur = (i_item.now_seconds > i_state.opened_at) ?
                 (i_item.now_seconds - i_state.opened_at) : '0;

    always_comb begin
        s         = i_state;
        ra        = '0;
        rb        = '0;
        retry_hit = 1'b0;
        event_hit = 1'b0;

        // retry the latched alert first
        if (s.pending_kind != deam_pkg::PEND_NONE) begin
            retry_hit = 1'b1;
            ra = deam_pkg::f_attempt(s.pending_kind, s.pending_enqueued, s.pending_open_sec,
                                     s.pending_lat, s.pending_lon, i_item, s.opening_count);
            s.pending_enqueued = s.pending_enqueued | ra.note_added;
            if (ra.delivered) begin
                if (s.pending_kind == deam_pkg::PEND_LONG) begin
                    s.long_alert_done = 1'b1;
                end
                s.pending_kind = deam_pkg::PEND_NONE;
            end
        end

        if (i_item.door_is_open && !s.door_latched_open) begin
            event_hit           = 1'b1;
            s.door_latched_open = 1'b1;
            s.opened_at         = i_item.now_seconds;
            s.long_alert_done   = 1'b0;
            s.opening_count     = s.opening_count + 1'b1;
            s.pending_open_sec  = '0;
            s.pending_kind      = deam_pkg::PEND_OPEN;
        end else if (!i_item.door_is_open && s.door_latched_open) begin
            event_hit           = 1'b1;
            s.door_latched_open = 1'b0;
            s.pending_open_sec  = dur;
            s.pending_kind      = deam_pkg::PEND_CLOSE;
        end else if (i_item.door_is_open && s.door_latched_open && !s.long_alert_done &&
                     s.pending_kind == deam_pkg::PEND_NONE &&
                     dur >= {{(deam_pkg::WORD_W-deam_pkg::LIMIT_W){1'b0}}, i_limit}) begin
            event_hit          = 1'b1;
            s.pending_open_sec = dur;
            s.pending_kind     = deam_pkg::PEND_LONG;
        end

        if (event_hit) begin
            s.pending_lat = i_item.latitude_word;
            s.pending_lon = i_item.longitude_word;
            rb = deam_pkg::f_attempt(s.pending_kind, 1'b0, s.pending_open_sec,
                                     s.pending_lat, s.pending_lon, i_item, s.opening_count);
            s.pending_enqueued = rb.note_added;
            if (rb.delivered) begin
                if (s.pending_kind == deam_pkg::PEND_LONG) begin
                    s.long_alert_done = 1'b1;
                end
                s.pending_kind = deam_pkg::PEND_NONE;
            end
        end

        o_state  = s;
        o_emit.any = retry_hit || event_hit;
        o_emit.two = retry_hit && event_hit;
        if (retry_hit) begin
            o_res0 = ra;
            o_res1 = rb;
        end else begin
            o_res0 = rb;
            o_res1 = rb;
        end
        o_res0.last_of_item = !(retry_hit && event_hit);
        o_res1.last_of_item = 1'b1;
    end

endmodule

`default_nettype wire

>>> rtl/door_event_alert_monitor_core.sv
// channel   | direction | handshake                       | payload
// ----------+-----------+---------------------------------+------------------------------------
// s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | tdata: door, time, temps, location,
//           |           |                                 |        enqueue_ok, sync_ok
// m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | tdata: alert fields; tuser: kind;
//           |           |                                 | tlast: last result of the item
// cfg       | in        | i_cfg_we                        | i_cfg_wdata: long-open limit (s)
//
// An item with two results keeps the next item from being processed until both of its beats
// drain, as the single result register pair drains one beat per cycle while i_m_axis_tready is
// high. An accepted item passes the input register, then the result register, before its first
// beat. Reset is synchronous, active low, and clears all alert state and sets the limit to
// 1800 s. A stalled output holds its beat while the input register still takes one more item.
`default_nettype none

module door_event_alert_monitor_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // door_is_open, now_seconds, probe1_temp, probe2_temp, latitude_word,
    // longitude_word, enqueue_ok, sync_ok, zero fill
    input  logic [deam_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // alert_door_flag, open_seconds, alert_latitude, alert_longitude, alert_temp1,
    // alert_temp2, note_added, delivered, open_event_count, zero fill
    output logic [deam_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // alert_kind
    output logic [deam_pkg::KIND_W-1:0]           o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [deam_pkg::LIMIT_W-1:0]          i_cfg_wdata
);

    deam_pkg::t_in     in_item;
    deam_pkg::t_in     r_in;
    logic              r_in_valid;
    deam_pkg::t_state  r_state;
    deam_pkg::t_state  n_state;
    deam_pkg::t_result r_res0;
    deam_pkg::t_result r_res1;
    deam_pkg::t_result n_res0;
    deam_pkg::t_result n_res1;
    deam_pkg::t_result out_res;
    deam_pkg::t_emit   emit;
    logic              r_out_valid;
    logic              r_second;
    logic              r_two;
    logic [deam_pkg::LIMIT_W-1:0] r_limit;
    logic              in_fire;
    logic              out_last;
    logic              out_free;
    logic              proc;

    assign in_item.door_is_open   = i_s_axis_tdata[0];
    assign in_item.now_seconds    = i_s_axis_tdata[32:1];
    assign in_item.probe1_temp    = i_s_axis_tdata[44:33];
    assign in_item.probe2_temp    = i_s_axis_tdata[56:45];
    assign in_item.latitude_word  = i_s_axis_tdata[88:57];
    assign in_item.longitude_word = i_s_axis_tdata[120:89];
    assign in_item.enqueue_ok     = i_s_axis_tdata[121];
    assign in_item.sync_ok        = i_s_axis_tdata[122];

    assign out_last        = !r_two || r_second;
    assign out_free        = !r_out_valid || (i_m_axis_tready && out_last);
    assign proc            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || proc;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    deam_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_limit (r_limit),
        .o_state (n_state),
        .o_res0  (n_res0),
        .o_res1  (n_res1),
        .o_emit  (emit)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= in_item;
        end
        if (proc) begin
            r_res0 <= n_res0;
            r_res1 <= n_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
            r_two       <= 1'b0;
            r_limit     <= deam_pkg::LIMIT_RESET;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_state     <= n_state;
                r_out_valid <= emit.any;
                r_two       <= emit.two;
                r_second    <= 1'b0;
            end else if (r_out_valid && i_m_axis_tready) begin
                // advance to the second beat or drop the pair
                if (out_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_second <= 1'b1;
                end
            end
        end
    end

    assign out_res = r_second ? r_res1 : r_res0;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = out_res.alert_kind;
    assign o_m_axis_tlast  = out_last;
    assign o_m_axis_tdata  = {5'b0,
                              out_res.open_event_count,
                              out_res.delivered,
                              out_res.note_added,
                              out_res.alert_temp2,
                              out_res.alert_temp1,
                              out_res.alert_longitude,
                              out_res.alert_latitude,
                              out_res.open_seconds,
                              out_res.alert_door_flag};

endmodule

`default_nettype wire

>>> rtl/deam_checker.sv
`default_nettype none

module deam_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [deam_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [deam_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic [deam_pkg::KIND_W-1:0]      o_m_axis_tuser,
    input logic                             o_m_axis_tlast,
    input logic                             i_cfg_we,
    input logic [deam_pkg::LIMIT_W-1:0]     i_cfg_wdata
);

    logic unused_in;
    assign unused_in = i_s_axis_tvalid ^ o_s_axis_tready ^ (^i_s_axis_tdata) ^
                       i_cfg_we ^ (^i_cfg_wdata);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat withdrawn while stalled");

    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && o_m_axis_tlast)
        else $error("second result of an item not presented next");

    a_open_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == deam_pkg::ALERT_OPEN |->
            o_m_axis_tdata[0] && o_m_axis_tdata[32:1] == 32'd0)
        else $error("open alert with closed flag or nonzero duration");

    a_closed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == deam_pkg::ALERT_CLOSED |-> !o_m_axis_tdata[0])
        else $error("closed alert reports door open");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != deam_pkg::ALERT_BAD)
        else $error("alert kind out of range");

endmodule

bind door_event_alert_monitor_core deam_checker u_deam_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_wdata     (i_cfg_wdata)
);

`default_nettype wire
